FILE: hw/rtl/stdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stdq_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int TAG_W   = 16;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
	localparam logic [OP_W-1:0] OP_RESOLVED   = 3'd1;
	localparam logic [OP_W-1:0] OP_DEP_FAILED = 3'd2;
	localparam logic [OP_W-1:0] OP_CANCEL     = 3'd3;
	localparam logic [OP_W-1:0] OP_POP        = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;
	localparam logic [OP_W-1:0] OP_QUERY      = 3'd6;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_DUP    = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_ABSENT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_REQ     = 2'd0,
		KIND_REQ_RDY = 2'd1,
		KIND_RTY     = 2'd2,
		KIND_RTY_RDY = 2'd3
	} kind_t;

	// Kind groups searched by pop and clear.
	typedef enum logic [1:0] {
		GRP_REQ     = 2'd0,
		GRP_RTY     = 2'd1,
		GRP_RTY_RDY = 2'd2
	} grp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_RESP
	} state_t;

	function automatic logic in_group(kind_t k, grp_t g);
		logic r;
		unique case (g)
			GRP_REQ:     r = (k == KIND_REQ) || (k == KIND_REQ_RDY);
			GRP_RTY:     r = (k == KIND_RTY);
			GRP_RTY_RDY: r = (k == KIND_RTY_RDY);
			default:     r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stdq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/sequenced_task_dispatch_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Pending-task table of ENTRIES slots keyed by a 32-bit sequence number. Keys and tags
// live in a small RAM that is walked one slot per cycle through its single read port,
// while one comparator either matches the beat's key or tracks the smallest key of a
// kind group. Each pass reads every slot and ends in an evaluation state, after which the
// result waits in a response state until the output register is free. Pop takes one or
// two passes, and clear-all takes one pass per emitted entry plus up to three more for
// exhausted groups. The block takes one input beat at a time; a finished result sits in the
// output register while the next beat is already being worked on. Slot valid bits are
// flops cleared by reset, so no clearing pass is needed after reset.
module sequenced_task_dispatch_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [stdq_pkg::OP_W-1:0]     opcode,
	input  logic [stdq_pkg::KEY_W-1:0]    seq_key,
	input  logic                          is_retry,
	input  logic [stdq_pkg::TAG_W-1:0]    task_tag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [stdq_pkg::STAT_W-1:0]   status,
	output logic                          task_valid,
	output logic [stdq_pkg::TAG_W-1:0]    out_tag,
	output logic                          ready_retry,
	output logic                          present,
	output logic                          deps_ready,
	output logic                          queue_empty,
	output logic                          last
);

	import stdq_pkg::*;

	state_t state_q, state_d;

	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic             retry_q;
	logic [TAG_W-1:0] tag_q;

	logic [ENTRIES-1:0] valid_q;
	kind_t              kind_q [ENTRIES];
	logic [CNT_W-1:0]   occ_q;

	logic [CNT_W-1:0] cnt_q;
	logic             scan_s1;
	logic [IDX_W-1:0] idx_s1;
	grp_t             grp_q;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [KEY_W-1:0] hit_key_q;
	logic [TAG_W-1:0] hit_tag_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;

	status_t          res_status_q;
	logic             res_tv_q;
	logic [TAG_W-1:0] res_tag_q;
	logic             res_skip_q;
	logic             res_pres_q;
	logic             res_rdy_q;
	logic             res_last_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_tv_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_skip_q;
	logic              out_pres_q;
	logic              out_rdy_q;
	logic              out_empty_q;
	logic              out_last_q;

	logic [KEY_W+TAG_W-1:0] rd_data;
	logic [KEY_W-1:0]       rd_key;
	logic [TAG_W-1:0]       rd_tag;
	logic                   ram_we;

	logic             min_pass;
	logic [KEY_W-1:0] cmp_b;
	logic             cmp_eq;
	logic             cmp_lt;
	logic             ent_valid;
	kind_t            ent_kind;
	kind_t            hit_kind;
	logic             take;
	logic             take_free;
	logic             scan_done;
	logic             scan_start;
	logic             out_free;
	logic             pop_take;
	logic             pop_retry;
	logic             clr_next;

	stdq_ram #(
		.WIDTH(KEY_W + TAG_W),
		.DEPTH(ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata({key_q, tag_q}),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign rd_key = rd_data[TAG_W +: KEY_W];
	assign rd_tag = rd_data[TAG_W-1:0];

	// Shared comparator: key match for lookups, running minimum for pop and clear.
	assign min_pass  = (op_q == OP_POP) || (op_q == OP_CLEAR);
	assign cmp_b     = min_pass ? hit_key_q : key_q;
	assign cmp_eq    = (rd_key == cmp_b);
	assign cmp_lt    = (rd_key < cmp_b);

	assign ent_valid = valid_q[idx_s1];
	assign ent_kind  = kind_q[idx_s1];
	assign hit_kind  = kind_q[hit_idx_q];

	assign take = scan_s1 && ent_valid &&
		(min_pass ? (in_group(ent_kind, grp_q) && (!hit_q || cmp_lt)) : (cmp_eq && !hit_q));
	assign take_free = scan_s1 && !ent_valid && !free_q && !min_pass;

	assign scan_done = (cnt_q == CNT_W'(ENTRIES)) && !scan_s1;
	assign out_free  = !out_valid_q || out_ready;

	// Head-of-line rule: the smallest request is taken only when it is ready.
	assign pop_take  = (op_q == OP_POP) && hit_q &&
		((grp_q == GRP_RTY_RDY) || (hit_kind == KIND_REQ_RDY));
	assign pop_retry = (op_q == OP_POP) && !hit_q && (grp_q == GRP_RTY_RDY);
	assign clr_next  = (op_q == OP_CLEAR) && !hit_q && (grp_q != GRP_RTY_RDY);

	assign ram_we = (state_q == ST_EVAL) && (op_q == OP_INSERT) && !hit_q && free_q;

	assign scan_start = (state_d == ST_SCAN) && (state_q != ST_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (opcode <= OP_QUERY) ? ST_SCAN : ST_RESP;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = (pop_retry || clr_next) ? ST_SCAN : ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ((op_q == OP_CLEAR) && !res_last_q) ? ST_SCAN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			occ_q       <= '0;
			cnt_q       <= '0;
			scan_s1     <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (scan_start) begin
				cnt_q   <= '0;
				scan_s1 <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (cnt_q != CNT_W'(ENTRIES)) begin
					cnt_q   <= cnt_q + CNT_W'(1);
					scan_s1 <= 1'b1;
				end else begin
					scan_s1 <= 1'b0;
				end
				if (take) begin
					hit_q <= 1'b1;
				end
				if (take_free) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == ST_EVAL) begin
				unique case (op_q)
					OP_INSERT: begin
						if (!hit_q && free_q) begin
							valid_q[free_idx_q] <= 1'b1;
							occ_q <= occ_q + CNT_W'(1);
						end
					end
					OP_DEP_FAILED: begin
						if (hit_q && (hit_kind != KIND_RTY_RDY)) begin
							valid_q[hit_idx_q] <= 1'b0;
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					OP_CANCEL, OP_CLEAR: begin
						if (hit_q) begin
							valid_q[hit_idx_q] <= 1'b0;
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					OP_POP: begin
						if (pop_take) begin
							valid_q[hit_idx_q] <= 1'b0;
							occ_q <= occ_q - CNT_W'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and datapath.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			op_q         <= opcode;
			key_q        <= seq_key;
			retry_q      <= is_retry;
			tag_q        <= task_tag;
			grp_q        <= (opcode == OP_POP) ? GRP_RTY_RDY : GRP_REQ;
			res_status_q <= STAT_OK;
			res_tv_q     <= 1'b0;
			res_tag_q    <= '0;
			res_skip_q   <= 1'b0;
			res_pres_q   <= 1'b0;
			res_rdy_q    <= 1'b0;
			res_last_q   <= 1'b1;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
			if (take) begin
				hit_idx_q <= idx_s1;
				hit_key_q <= rd_key;
				hit_tag_q <= rd_tag;
			end
			if (take_free) begin
				free_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_EVAL) begin
			unique case (op_q)
				OP_INSERT: begin
					if (hit_q) begin
						res_status_q <= STAT_DUP;
					end else if (!free_q) begin
						res_status_q <= STAT_FULL;
					end else begin
						kind_q[free_idx_q] <= retry_q ? KIND_RTY : KIND_REQ;
					end
				end
				OP_RESOLVED: begin
					if (hit_q && (hit_kind == KIND_REQ)) begin
						kind_q[hit_idx_q] <= KIND_REQ_RDY;
					end else if (hit_q && (hit_kind == KIND_RTY)) begin
						kind_q[hit_idx_q] <= KIND_RTY_RDY;
					end
				end
				OP_QUERY: begin
					if (!hit_q) begin
						res_status_q <= STAT_ABSENT;
					end else begin
						res_pres_q <= 1'b1;
						res_rdy_q  <= (hit_kind == KIND_REQ_RDY) || (hit_kind == KIND_RTY_RDY);
					end
				end
				OP_POP: begin
					if (pop_take) begin
						res_tv_q   <= 1'b1;
						res_tag_q  <= hit_tag_q;
						res_skip_q <= (grp_q == GRP_RTY_RDY);
					end
					if (pop_retry) begin
						grp_q <= GRP_REQ;
					end
				end
				OP_CLEAR: begin
					if (hit_q) begin
						res_tv_q   <= 1'b1;
						res_tag_q  <= hit_tag_q;
						res_last_q <= (occ_q == CNT_W'(1));
					end else if (clr_next) begin
						grp_q <= (grp_q == GRP_REQ) ? GRP_RTY : GRP_RTY_RDY;
					end else begin
						res_tv_q   <= 1'b0;
						res_tag_q  <= '0;
						res_last_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if ((state_q == ST_RESP) && out_free) begin
			out_status_q <= res_status_q;
			out_tv_q     <= res_tv_q;
			out_tag_q    <= res_tag_q;
			out_skip_q   <= res_skip_q;
			out_pres_q   <= res_pres_q;
			out_rdy_q    <= res_rdy_q;
			// Every clear beat reports an empty table.
			out_empty_q  <= (op_q == OP_CLEAR) || (occ_q == '0);
			out_last_q   <= res_last_q;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign task_valid  = out_tv_q;
	assign out_tag     = out_tag_q;
	assign ready_retry = out_skip_q;
	assign present     = out_pres_q;
	assign deps_ready  = out_rdy_q;
	assign queue_empty = out_empty_q;
	assign last        = out_last_q;

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CNT_W'($countones(valid_q)))
		else $error("occupancy count disagrees with slot valid bits");

	a_hit_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) && hit_q |-> valid_q[hit_idx_q])
		else $error("selected slot is not valid at evaluation");

	a_tag_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_tv_q |-> (out_status_q == STAT_OK) && !out_pres_q && !out_rdy_q)
		else $error("tag beat carries query or error fields");

endmodule

`default_nettype wire

FILE: test/tb_sequenced_task_dispatch_queue.sv
`timescale 1ns / 1ps

import stdq_pkg::*;

typedef struct {
	status_t          status;
	logic             task_valid;
	logic [TAG_W-1:0] out_tag;
	logic             ready_retry;
	logic             present;
	logic             deps_ready;
	logic             queue_empty;
	logic             last;
} dispatch_result_t;

class task_table_model;
	bit               slot_valid [ENTRIES];
	kind_t            slot_kind  [ENTRIES];
	logic [KEY_W-1:0] slot_key   [ENTRIES];
	logic [TAG_W-1:0] slot_tag   [ENTRIES];
	dispatch_result_t pending_results [$];
	int mismatches;
	int beats_in;
	int beats_out;
	int tags_out;
	int blocked_pops;
	int dup_rejects;
	int full_rejects;

	function bit [3:0] kind_bit(kind_t k);
		return 4'b0001 << k;
	endfunction

	function int find_key(logic [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// Slot with the smallest key among held entries whose kind is in the mask.
	function int lowest(bit [3:0] kinds);
		int best;
		best = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_valid[i] && kinds[slot_kind[i]]) begin
				if (best < 0 || slot_key[i] < slot_key[best])
					best = i;
			end
		end
		return best;
	endfunction

	function int held();
		int n;
		n = 0;
		for (int i = 0; i < ENTRIES; i++)
			n += slot_valid[i];
		return n;
	endfunction

	function logic [KEY_W-1:0] random_held_key(output bit found);
		int slots [$];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i])
				slots.insert(slots.size(), i);
		found = (slots.size() != 0);
		if (!found)
			return '0;
		return slot_key[slots[$urandom_range(0, slots.size() - 1)]];
	endfunction

	function void add_result(status_t st, logic tv, logic [TAG_W-1:0] t, logic sk,
				 logic pr, logic rd, logic emp, logic lst);
		dispatch_result_t r;
		r.status      = st;
		r.task_valid  = tv;
		r.out_tag     = t;
		r.ready_retry = sk;
		r.present     = pr;
		r.deps_ready  = rd;
		r.queue_empty = emp;
		r.last        = lst;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function void drain_kinds(bit [3:0] kinds);
		int s;
		s = lowest(kinds);
		while (s >= 0) begin
			add_result(STAT_OK, 1'b1, slot_tag[s], 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
			slot_valid[s] = 1'b0;
			tags_out++;
			s = lowest(kinds);
		end
	endfunction

	function void note_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic retry,
				logic [TAG_W-1:0] t);
		int idx;
		int s;
		int before_n;
		status_t st;
		logic tv, sk, pr, rd;
		logic [TAG_W-1:0] ot;
		st = STAT_OK;
		tv = 1'b0;
		sk = 1'b0;
		pr = 1'b0;
		rd = 1'b0;
		ot = '0;
		beats_in++;
		idx = find_key(k);
		if (op == OP_CLEAR) begin
			// Requests of both readiness go first, then waiting retries, then ready ones.
			before_n = pending_results.size();
			drain_kinds(kind_bit(KIND_REQ) | kind_bit(KIND_REQ_RDY));
			drain_kinds(kind_bit(KIND_RTY));
			drain_kinds(kind_bit(KIND_RTY_RDY));
			if (pending_results.size() == before_n)
				add_result(STAT_OK, 1'b0, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
			else
				pending_results[pending_results.size() - 1].last = 1'b1;
			return;
		end
		case (op)
			OP_INSERT: begin
				s = -1;
				for (int i = ENTRIES - 1; i >= 0; i--)
					if (!slot_valid[i])
						s = i;
				if (idx >= 0) begin
					st = STAT_DUP;
					dup_rejects++;
				end else if (s < 0) begin
					st = STAT_FULL;
					full_rejects++;
				end else begin
					slot_valid[s] = 1'b1;
					slot_kind[s]  = retry ? KIND_RTY : KIND_REQ;
					slot_key[s]   = k;
					slot_tag[s]   = t;
				end
			end
			OP_RESOLVED: begin
				if (idx >= 0) begin
					if (slot_kind[idx] == KIND_REQ)
						slot_kind[idx] = KIND_REQ_RDY;
					else if (slot_kind[idx] == KIND_RTY)
						slot_kind[idx] = KIND_RTY_RDY;
				end
			end
			OP_DEP_FAILED: begin
				if (idx >= 0 && slot_kind[idx] != KIND_RTY_RDY)
					slot_valid[idx] = 1'b0;
			end
			OP_CANCEL: begin
				if (idx >= 0)
					slot_valid[idx] = 1'b0;
			end
			OP_POP: begin
				s = lowest(kind_bit(KIND_RTY_RDY));
				if (s >= 0) begin
					sk = 1'b1;
				end else begin
					// Only the oldest request may leave; if it is not ready, nothing does.
					s = lowest(kind_bit(KIND_REQ) | kind_bit(KIND_REQ_RDY));
					if (s >= 0 && slot_kind[s] != KIND_REQ_RDY) begin
						s = -1;
						blocked_pops++;
					end
				end
				if (s >= 0) begin
					tv = 1'b1;
					ot = slot_tag[s];
					slot_valid[s] = 1'b0;
					tags_out++;
				end
			end
			OP_QUERY: begin
				if (idx < 0) begin
					st = STAT_ABSENT;
				end else begin
					pr = 1'b1;
					rd = (slot_kind[idx] == KIND_REQ_RDY) || (slot_kind[idx] == KIND_RTY_RDY);
				end
			end
			default: begin
			end
		endcase
		add_result(st, tv, ot, sk, pr, rd, held() == 0, 1'b1);
	endfunction

	task report(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < 40)
			$display("MISMATCH beat %0d: %s got %0h, want %0h", beats_out, field, got, want);
		mismatches++;
	endtask

	task check_beat(dispatch_result_t got);
		dispatch_result_t want;
		beats_out++;
		if (pending_results.size() == 0) begin
			report("unexpected beat, out_tag", got.out_tag, '0);
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status)
			report("status", got.status, want.status);
		if (got.task_valid !== want.task_valid)
			report("task_valid", got.task_valid, want.task_valid);
		if (got.out_tag !== want.out_tag)
			report("out_tag", got.out_tag, want.out_tag);
		if (got.ready_retry !== want.ready_retry)
			report("ready_retry", got.ready_retry, want.ready_retry);
		if (got.present !== want.present)
			report("present", got.present, want.present);
		if (got.deps_ready !== want.deps_ready)
			report("deps_ready", got.deps_ready, want.deps_ready);
		if (got.queue_empty !== want.queue_empty)
			report("queue_empty", got.queue_empty, want.queue_empty);
		if (got.last !== want.last)
			report("last", got.last, want.last);
	endtask
endclass

module tb_sequenced_task_dispatch_queue;

	localparam logic [OP_W-1:0] OP_UNUSED    = 3'd7;
	localparam int              RANDOM_BEATS = 420;
	localparam int              DRAIN_CYCLES = 20 * (ENTRIES + 4);
	localparam int unsigned     LIMIT        = 1000000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [OP_W-1:0]    opcode;
	logic [KEY_W-1:0]   seq_key;
	logic               is_retry;
	logic [TAG_W-1:0]   task_tag;
	logic               out_valid;
	logic               out_ready;
	logic [STAT_W-1:0]  status;
	logic               task_valid;
	logic [TAG_W-1:0]   out_tag;
	logic               ready_retry;
	logic               present;
	logic               deps_ready;
	logic               queue_empty;
	logic               last;

	task_table_model tbl;
	bit              calm;
	int              beats_sent;
	int unsigned     cycles;

	sequenced_task_dispatch_queue u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.seq_key    (seq_key),
		.is_retry   (is_retry),
		.task_tag   (task_tag),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.task_valid (task_valid),
		.out_tag    (out_tag),
		.ready_retry(ready_retry),
		.present    (present),
		.deps_ready (deps_ready),
		.queue_empty(queue_empty),
		.last       (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);
	end

	// Outputs are stable at the falling edge; a beat seen here is taken at the next rise.
	always @(negedge clk) begin
		dispatch_result_t r;
		if (arst_n && out_valid && out_ready) begin
			r.status      = status_t'(status);
			r.task_valid  = task_valid;
			r.out_tag     = out_tag;
			r.ready_retry = ready_retry;
			r.present     = present;
			r.deps_ready  = deps_ready;
			r.queue_empty = queue_empty;
			r.last        = last;
			tbl.check_beat(r);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles,
				 tbl.pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [TAG_W-1:0] rand_tag();
		return TAG_W'($urandom);
	endfunction

	// Called just after a rising edge; returns just after the edge that took the beat.
	task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic retry,
				 logic [TAG_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 27)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		seq_key  <= k;
		is_retry <= retry;
		task_tag <= t;
		do @(negedge clk); while (!in_ready);
		tbl.note_beat(op, k, retry, t);
		if (op != OP_UNUSED)
			beats_sent++;
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] fresh_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return $urandom_range(0, 63);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] target_key(int held_pct);
		bit found;
		logic [KEY_W-1:0] k;
		k = tbl.random_held_key(found);
		if (found && $urandom_range(0, 99) < held_pct)
			return k;
		return fresh_key();
	endfunction

	task automatic fill_table();
		while (tbl.held() < ENTRIES)
			send_item(OP_INSERT, fresh_key(), rand_bit(), rand_tag());
		send_item(OP_INSERT, fresh_key(), rand_bit(), rand_tag());
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 28)
			send_item(OP_INSERT, target_key(15), rand_bit(), rand_tag());
		else if (r < 50)
			send_item(OP_RESOLVED, target_key(80), rand_bit(), rand_tag());
		else if (r < 56)
			send_item(OP_DEP_FAILED, target_key(80), rand_bit(), rand_tag());
		else if (r < 62)
			send_item(OP_CANCEL, target_key(80), rand_bit(), rand_tag());
		else if (r < 84)
			send_item(OP_POP, $urandom, rand_bit(), rand_tag());
		else if (r < 87)
			send_item(OP_CLEAR, $urandom, rand_bit(), rand_tag());
		else if (r < 97)
			send_item(OP_QUERY, target_key(70), rand_bit(), rand_tag());
		else
			send_item(OP_UNUSED, $urandom, rand_bit(), rand_tag());
	endtask

	initial begin
		tbl        = new;
		calm       = 1'b0;
		beats_sent = 0;
		cycles     = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_INSERT;
		seq_key   <= '0;
		is_retry  <= 1'b0;
		task_tag  <= '0;
		out_ready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, unknown opcode and the key and tag extremes.
		send_item(OP_POP, '0, 1'b0, '0);
		send_item(OP_CLEAR, '0, 1'b0, '0);
		send_item(OP_QUERY, '1, 1'b0, '0);
		send_item(OP_UNUSED, '1, 1'b1, '1);
		send_item(OP_INSERT, '0, 1'b0, '0);
		send_item(OP_INSERT, '1, 1'b1, '1);
		// The oldest request is not ready, so pop is blocked even with a retry held.
		send_item(OP_POP, '0, 1'b0, '0);
		send_item(OP_RESOLVED, '1, 1'b0, '0);
		send_item(OP_RESOLVED, '1, 1'b0, '0);
		send_item(OP_DEP_FAILED, '1, 1'b0, '0);
		send_item(OP_RESOLVED, '0, 1'b0, '0);
		send_item(OP_QUERY, '0, 1'b0, '0);
		for (int i = 0; i < ENTRIES - 2; i++)
			send_item(OP_INSERT, 32'h0000_0100 + i, i[0], rand_tag());
		// Table is full now; a held key still reports a duplicate first.
		send_item(OP_INSERT, 32'h5555_5555, 1'b0, 16'h5555);
		send_item(OP_INSERT, '1, 1'b1, 16'hAAAA);
		send_item(OP_DEP_FAILED, 32'h0000_0101, 1'b0, '0);
		send_item(OP_POP, '0, 1'b0, '0);
		send_item(OP_POP, '0, 1'b0, '0);
		send_item(OP_CLEAR, '0, 1'b0, '0);

		beats_sent = 0;
		while (beats_sent < RANDOM_BEATS) begin
			calm = (beats_sent >= 150 && beats_sent < 260);
			if ($urandom_range(0, 99) < 4)
				fill_table();
			else
				random_item();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (tbl.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input beats and %0d result beats, %0d tags handed out",
			 tbl.beats_in, tbl.beats_out, tbl.tags_out);
		$display("%0d pops held back by an unready head, %0d duplicate and %0d full inserts",
			 tbl.blocked_pops, tbl.dup_rejects, tbl.full_rejects);
		if (tbl.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
